// ----- rtl/core/btpc_pkg.sv -----
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types, constants and register codes for the compensation core.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int RAW_W  = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_W  = 64;

  localparam logic [CFG_IDX_W-1:0] REG_T1    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T2    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T3    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P2_P3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P4_P5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P6_P7 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_P8_P9 = 3'd7;

  typedef struct packed {
    logic [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // item riding along the divider
  typedef struct packed {
    logic signed [31:0] centi;
    logic signed [31:0] fine;
    logic               dz;
  } side_t;

endpackage

// ----- rtl/core/btpc_if.sv -----
// ----------------------------------------------------------------------------
// btpc channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic signed [31:0] fine_temperature;
  logic signed [63:0] pressure_fixed;
  logic               divide_by_zero;
  modport source (output valid, output temperature_centi, output fine_temperature,
                  output pressure_fixed, output divide_by_zero, input ready);
  modport sink (input valid, input temperature_centi, input fine_temperature,
                input pressure_fixed, input divide_by_zero, output ready);
endinterface

interface btpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/baro_temp_press_compensation_core.sv -----
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_core
// Integer temperature and pressure compensation of raw barometric samples.
//
//   channel | dir | words
//   in_     | in  | raw_temperature, raw_pressure
//   out_    | out | temperature_centi, fine_temperature, pressure_fixed, flag
//   cfg_    | in  | index, data (eight calibration registers)
//
// one word accepted per cycle while the pipe advances (9 pre-divide stages,
// 65 divider stages, 7 post-divide stages, output register)
// rst_n clears all valid bits and the calibration registers
// the whole pipe advances when the output register is empty or taken
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_core import btpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  btpc_in_if.sink    in_ch,
  btpc_out_if.source out_ch,
  btpc_cfg_if.sink   cfg_ch
);

  cal_t cal;
  logic en;

  btpc_regs u_regs (.clk(clk), .rst_n(rst_n), .cfg(cfg_ch), .cal(cal));

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- pre-divide pipe ----------------
  logic [8:0] pv_r;
  logic [19:0] rp_r [8];
  // s1
  logic signed [31:0] s1_ta_r, s1_d_r;
  // s2
  logic signed [31:0] s2_a_r, s2_dd_r;
  // s3
  logic signed [31:0] s3_a_r, s3_b_r;
  // s4
  logic signed [31:0] s4_fine_r;
  logic signed [63:0] s4_x_r;
  // s5
  logic signed [31:0] s5_fine_r, s5_c5_r;
  logic signed [63:0] s5_xx_r, s5_xp5_r, s5_xp2_r;
  // s6
  logic signed [31:0] s6_fine_r, s6_c_r;
  logic signed [63:0] s6_y_r, s6_xx3_r, s6_xp2_r;
  // s7
  logic signed [31:0] s7_fine_r, s7_c_r;
  logic signed [63:0] s7_y_r, s7_x_r;
  // s8
  logic signed [31:0] s8_fine_r, s8_c_r;
  logic signed [63:0] s8_y_r, s8_dv_r;
  // s9
  logic signed [31:0] s9_fine_r, s9_c_r;
  logic signed [63:0] s9_num_r, s9_den_r;

  logic signed [31:0] t1s, rt3, rt4;
  logic signed [31:0] s3_b_nxt, s4_c_nxt;
  logic signed [31:0] fine5_nxt;
  logic signed [32:0] s4_xh;
  logic signed [65:0] s5_xx_nxt;
  logic signed [63:0] s9_num_nxt;
  logic signed [63:0] pr_base;

  always_comb begin
    t1s  = {16'd0, cal.t1};
    rt3  = 32'(in_ch.raw_temperature >> 3);
    rt4  = 32'(in_ch.raw_temperature >> 4);
    s3_b_nxt = (s2_dd_r >>> 12) * 32'(cal.t3);
    fine5_nxt = s3_a_r + (s3_b_r >>> 14);
    s4_c_nxt = s4_fine_r * 32'sd5 + 32'sd128;
    // x fits in 33 signed bits
    s4_xh = s4_x_r[32:0];
    s5_xx_nxt = s4_xh * s4_xh;
    pr_base = 64'(21'd1048576 - {1'b0, rp_r[7]});
    s9_num_nxt = ((pr_base <<< 31) - s8_y_r) * 64'sd3125;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[7:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp_r[0] <= in_ch.raw_pressure;
      for (int i = 1; i < 8; i++) rp_r[i] <= rp_r[i-1];
      s1_ta_r <= rt3 - (t1s <<< 1);
      s1_d_r  <= rt4 - t1s;
      s2_a_r  <= (s1_ta_r * 32'(cal.t2)) >>> 11;
      s2_dd_r <= s1_d_r * s1_d_r;
      s3_a_r  <= s2_a_r;
      s3_b_r  <= s3_b_nxt;
      s4_fine_r <= fine5_nxt;
      s4_x_r  <= 64'(fine5_nxt) - 64'sd128000;
      s5_fine_r <= s4_fine_r;
      s5_c5_r <= s4_c_nxt >>> 8;
      s5_xx_r <= s5_xx_nxt[63:0];
      s5_xp5_r <= s4_x_r * 64'(cal.p5);
      s5_xp2_r <= s4_x_r * 64'(cal.p2);
      s6_fine_r <= s5_fine_r;
      s6_c_r  <= s5_c5_r;
      s6_y_r  <= s5_xx_r * 64'(cal.p6) + (s5_xp5_r <<< 17) + (64'(cal.p4) <<< 35);
      s6_xx3_r <= s5_xx_r * 64'(cal.p3);
      s6_xp2_r <= s5_xp2_r;
      s7_fine_r <= s6_fine_r;
      s7_c_r  <= s6_c_r;
      s7_y_r  <= s6_y_r;
      s7_x_r  <= (s6_xx3_r >>> 8) + (s6_xp2_r <<< 12);
      s8_fine_r <= s7_fine_r;
      s8_c_r  <= s7_c_r;
      s8_y_r  <= s7_y_r;
      s8_dv_r <= ((64'sd1 <<< 47) + s7_x_r) * 64'({48'd0, cal.p1});
      s9_fine_r <= s8_fine_r;
      s9_c_r  <= s8_c_r;
      s9_num_r <= s9_num_nxt;
      s9_den_r <= s8_dv_r >>> 33;
    end
  end

  // ---------------- divider ----------------
  side_t div_side, dq_side;
  logic  dq_valid;
  logic signed [63:0] dq, div_den;

  assign div_side = '{centi: s9_c_r, fine: s9_fine_r, dz: (s9_den_r == 64'sd0)};
  assign div_den  = (s9_den_r == 64'sd0) ? 64'sd1 : s9_den_r;

  btpc_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(pv_r[8]), .in_num(s9_num_r), .in_den(div_den), .in_side(div_side),
    .out_valid(dq_valid), .out_quo(dq), .out_side(dq_side)
  );

  // ---------------- post-divide pipe ----------------
  logic [6:0] qv_r;
  side_t q_side_r [7];
  logic signed [63:0] q1_pr_r, q1_s_r;
  logic signed [63:0] q2_pr_r, q2_ss_r, q2_p8_r;
  logic signed [63:0] q3_pr_r, q3_y_r;
  logic [63:0]        q3_ll_r;
  logic [31:0]        q3_cross_r;
  logic signed [63:0] q4_pr_r, q4_x_r, q4_y_r;
  logic signed [63:0] q5_sum_r;
  logic signed [63:0] q6_pr_r, q7_pr_r;

  logic signed [63:0] q2_s;
  logic [63:0]        q3_ll_nxt;
  logic [31:0]        q3_cross_nxt;

  // 64-bit wrapped product split into 32x32 partial products
  always_comb begin
    q2_s = q2_pr_r >>> 13;
    q3_ll_nxt = q2_ss_r[31:0] * q2_s[31:0];
    q3_cross_nxt = q2_ss_r[31:0] * q2_s[63:32] + q2_ss_r[63:32] * q2_s[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= '0;
    end else if (en) begin
      qv_r <= {qv_r[5:0], dq_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_side_r[0] <= dq_side;
      for (int i = 1; i < 7; i++) q_side_r[i] <= q_side_r[i-1];
      q1_pr_r <= dq;
      q1_s_r  <= dq >>> 13;
      q2_pr_r <= q1_pr_r;
      q2_ss_r <= q1_s_r * 64'(cal.p9);
      q2_p8_r <= q1_pr_r * 64'(cal.p8);
      q3_pr_r <= q2_pr_r;
      q3_ll_r <= q3_ll_nxt;
      q3_cross_r <= q3_cross_nxt;
      q3_y_r  <= q2_p8_r >>> 19;
      q4_pr_r <= q3_pr_r;
      q4_x_r  <= q3_ll_r + {q3_cross_r, 32'd0};
      q4_y_r  <= q3_y_r;
      q5_sum_r <= q4_pr_r + (q4_x_r >>> 25) + q4_y_r;
      q6_pr_r <= (q5_sum_r >>> 8) + (64'(cal.p7) <<< 4);
      q7_pr_r <= q6_pr_r;
    end
  end

  // ---------------- output register ----------------
  logic               ov_r;
  logic signed [31:0] oc_r, of_r;
  logic signed [63:0] op_r;
  logic               odz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= qv_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oc_r  <= q_side_r[6].centi;
      of_r  <= q_side_r[6].fine;
      odz_r <= q_side_r[6].dz;
      op_r  <= q_side_r[6].dz ? 64'sd0 : q7_pr_r;
    end
  end

  assign out_ch.valid             = ov_r;
  assign out_ch.temperature_centi = oc_r;
  assign out_ch.fine_temperature  = of_r;
  assign out_ch.pressure_fixed    = op_r;
  assign out_ch.divide_by_zero    = odz_r;

  property p_hold;
    @(posedge clk) disable iff (!rst_n) (out_ch.valid && !out_ch.ready) |=> out_ch.valid;
  endproperty
  a_hold: assert property (p_hold) else $error("result lost while stalled");

  property p_dz_zero;
    @(posedge clk) disable iff (!rst_n)
      (out_ch.valid && out_ch.divide_by_zero) |-> (out_ch.pressure_fixed == 64'sd0);
  endproperty
  a_dz_zero: assert property (p_dz_zero) else $error("zero divisor with nonzero pressure");

  property p_ready;
    @(posedge clk) disable iff (!rst_n) in_ch.ready == (!out_ch.valid || out_ch.ready);
  endproperty
  a_ready: assert property (p_ready) else $error("input ready mismatch");

endmodule

// ----- rtl/core/btpc_regs.sv -----
// ----------------------------------------------------------------------------
// btpc_regs
// Calibration coefficient registers written through the configuration port.
// ----------------------------------------------------------------------------
module btpc_regs import btpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  btpc_cfg_if.sink   cfg,
  output cal_t       cal
);

  cal_t cal_r;

  assign cfg.ready = 1'b1;
  assign cal = cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_T1:    cal_r.t1 <= cfg.data[15:0];
        REG_T2:    cal_r.t2 <= cfg.data[15:0];
        REG_T3:    cal_r.t3 <= cfg.data[15:0];
        REG_P1:    cal_r.p1 <= cfg.data[15:0];
        REG_P2_P3: begin
          cal_r.p2 <= cfg.data[15:0];
          cal_r.p3 <= cfg.data[31:16];
        end
        REG_P4_P5: begin
          cal_r.p4 <= cfg.data[15:0];
          cal_r.p5 <= cfg.data[31:16];
        end
        REG_P6_P7: begin
          cal_r.p6 <= cfg.data[15:0];
          cal_r.p7 <= cfg.data[31:16];
        end
        REG_P8_P9: begin
          cal_r.p8 <= cfg.data[15:0];
          cal_r.p9 <= cfg.data[31:16];
        end
        default: cal_r <= cal_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/btpc_div.sv -----
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined signed 64-bit truncating divider, one quotient bit per stage,
// with a side word carried alongside; advances only when en is high.
// ----------------------------------------------------------------------------
module btpc_div import btpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [DIV_W-1:0] in_num,
  input  logic signed [DIV_W-1:0] in_den,
  input  side_t                  in_side,
  output logic                   out_valid,
  output logic signed [DIV_W-1:0] out_quo,
  output side_t                  out_side
);

  localparam int N = DIV_W;

  logic [N:0]       vld_r;
  logic [N-1:0]     rem_r [N+1];
  logic [N-1:0]     quo_r [N+1];
  logic [N-1:0]     den_r [N+1];
  logic             neg_r [N+1];
  side_t            side_r [N+1];

  logic [N-1:0] nm, dm;

  assign nm = in_num[N-1] ? (~in_num + 1'b1) : in_num;
  assign dm = in_den[N-1] ? (~in_den + 1'b1) : in_den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      quo_r[0]  <= nm;
      den_r[0]  <= dm;
      neg_r[0]  <= in_num[N-1] ^ in_den[N-1];
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [N:0]   trial;
    logic [N-1:0] shifted;
    always_comb begin
      shifted = {rem_r[s][N-2:0], quo_r[s][N-1]};
      trial   = {rem_r[s][N-1], shifted} - {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[N]) begin
          rem_r[s+1] <= trial[N-1:0];
          quo_r[s+1] <= {quo_r[s][N-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= shifted;
          quo_r[s+1] <= {quo_r[s][N-2:0], 1'b0};
        end
        den_r[s+1]  <= den_r[s];
        neg_r[s+1]  <= neg_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_quo   = neg_r[N] ? (~quo_r[N] + 1'b1) : quo_r[N];
  assign out_side  = side_r[N];

endmodule

// ----- bench/baro_temp_press_compensation_core_tb.sv -----
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_core_tb
// Drives raw sample words through the compensation core under random idling
// on both channels, predicts each result word from the calibration registers,
// and compares every output field in order across several register settings.
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_core_tb;
  import btpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [19:0] rt;
    logic [19:0] rp;
  } sample_t;

  typedef struct {
    logic [31:0] centi;
    logic [31:0] fine;
    logic [63:0] press;
    logic        dz;
  } comp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  btpc_in_if  in_ch();
  btpc_out_if out_ch();
  btpc_cfg_if cfg_ch();

  baro_temp_press_compensation_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  logic [31:0] cal [8];
  sample_t     sample_q[$];
  comp_t       comp_q[$];
  int          errors = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          gap_max = 17;
  logic        in_fire = 1'b0;

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
    logic [63:0] nm, dm, q;
    nm = n[63] ? -n : n;
    dm = d[63] ? -d : d;
    q = nm / dm;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_t compensate(sample_t s);
    comp_t r;
    logic [31:0] t1, t2, t3, a, b, d;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x, y, dv, pr, sh, tq;
    t1 = {16'd0, cal[REG_T1][15:0]};
    t2 = 32'(signed'(cal[REG_T2][15:0]));
    t3 = 32'(signed'(cal[REG_T3][15:0]));
    p1 = {48'd0, cal[REG_P1][15:0]};
    p2 = sx16(cal[REG_P2_P3][15:0]);
    p3 = sx16(cal[REG_P2_P3][31:16]);
    p4 = sx16(cal[REG_P4_P5][15:0]);
    p5 = sx16(cal[REG_P4_P5][31:16]);
    p6 = sx16(cal[REG_P6_P7][15:0]);
    p7 = sx16(cal[REG_P6_P7][31:16]);
    p8 = sx16(cal[REG_P8_P9][15:0]);
    p9 = sx16(cal[REG_P8_P9][31:16]);
    a = 32'(((32'(s.rt) >> 3) - (t1 << 1)) * t2);
    a = $signed(a) >>> 11;
    d = (32'(s.rt) >> 4) - t1;
    b = 32'(d * d);
    b = $signed(b) >>> 12;
    b = 32'(b * t3);
    b = $signed(b) >>> 14;
    r.fine = a + b;
    r.centi = 32'(r.fine * 5 + 128);
    r.centi = $signed(r.centi) >>> 8;
    x = {{32{r.fine[31]}}, r.fine} - 64'd128000;
    y = x * x * p6;
    y = y + ((x * p5) << 17);
    y = y + (p4 << 35);
    tq = $signed(x * x * p3) >>> 8;
    x = tq + ((x * p2) << 12);
    dv = $signed(((64'd1 << 47) + x) * p1) >>> 33;
    if (dv == 0) begin
      r.dz = 1'b1;
      r.press = 0;
    end else begin
      r.dz = 1'b0;
      pr = 64'd1048576 - {44'd0, s.rp};
      pr = sdiv(((pr << 31) - y) * 64'd3125, dv);
      sh = $signed(pr) >>> 13;
      x = $signed(p9 * sh * sh) >>> 25;
      y = $signed(p8 * pr) >>> 19;
      tq = $signed(pr + x + y) >>> 8;
      r.press = tq + (p7 << 4);
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // input word taken at the last rising edge
  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
    end else if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (sample_q.size() > 0) begin
      sample_t s;
      s = sample_q.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.raw_temperature <= s.rt;
      in_ch.raw_pressure <= s.rp;
      comp_q.push_back(compensate(s));
      in_gap <= $urandom_range(0, gap_max);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // output stall
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid) out_gap <= $urandom_range(0, gap_max);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (comp_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        comp_t e;
        e = comp_q.pop_front();
        if (out_ch.temperature_centi !== e.centi)
          report("temperature_centi", 64'(out_ch.temperature_centi), 64'(e.centi));
        if (out_ch.fine_temperature !== e.fine)
          report("fine_temperature", 64'(out_ch.fine_temperature), 64'(e.fine));
        if (out_ch.pressure_fixed !== e.press)
          report("pressure_fixed", out_ch.pressure_fixed, e.press);
        if (out_ch.divide_by_zero !== e.dz)
          report("divide_by_zero", 64'(out_ch.divide_by_zero), 64'(e.dz));
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cal[idx] = val & ((idx < REG_P2_P3) ? 32'hffff : 32'hffff_ffff);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || comp_q.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic push(logic [19:0] rt, logic [19:0] rp);
    sample_t s;
    s.rt = rt;
    s.rp = rp;
    sample_q.push_back(s);
  endtask

  task automatic load_cal(int mode);
    for (int i = 0; i < 8; i++) begin
      logic [31:0] v;
      case (mode)
        0: v = 32'h0;
        1: v = 32'hffff_ffff;
        2: v = (i < 4) ? 32'h8000 : 32'h8000_8000;
        3: v = (i < 4) ? 32'h7fff : 32'h7fff_7fff;
        default: v = $urandom();
      endcase
      if (mode >= 5) begin
        // realistic sensor-like coefficients with random spread
        case (i)
          REG_T1: v = 27000 + $urandom_range(0, 2000);
          REG_T2: v = 26000 + $urandom_range(0, 1000);
          REG_T3: v = 16'(-1000);
          REG_P1: v = 36000 + $urandom_range(0, 2000);
          REG_P2_P3: v = {16'd3024, 16'(-10700)};
          REG_P4_P5: v = {16'(-30 - $urandom_range(0, 100)), 16'd2855};
          REG_P6_P7: v = {16'd15500, 16'(-7)};
          REG_P8_P9: v = {16'd6000, 16'(-14600)};
          default: ;
        endcase
      end
      write_reg(3'(i), v);
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int i = 0; i < 8; i++) cal[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset coefficients give zero divisor
    push(20'h0, 20'h0);
    push(20'hfffff, 20'hfffff);
    drain();
    for (int m = 1; m < 6; m++) begin
      load_cal(m);
      push(20'h0, 20'h0);
      push(20'hfffff, 20'hfffff);
      push(20'h80000, 20'h55555);
      push(20'h7ec00, 20'h65000);
      drain();
    end

    for (int ph = 0; ph < 10; ph++) begin
      load_cal((ph % 3 == 0) ? 4 : 5);
      gap_max = (ph % 4 == 3) ? 0 : 17;
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) == 0)
          push(20'($urandom()), 20'($urandom()));
        else
          push(20'(480000 + $urandom_range(0, 90000)),
               20'(250000 + $urandom_range(0, 200000)));
      end
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
